[design/qrs_pkg.sv]
`timescale 1ns / 1ps
package qrs_pkg;
    // width of each root on the result channel
    localparam int ROOT_W = 34;
    localparam int CASE_W = 2;

    typedef logic [CASE_W-1:0] root_case_t;

    // classification codes
    localparam root_case_t CASE_TWO    = 2'd0;
    localparam root_case_t CASE_DOUBLE = 2'd1;
    localparam root_case_t CASE_NONE   = 2'd2;
    localparam root_case_t CASE_DEGEN  = 2'd3;
endpackage

[design/qrs_if.sv]
`timescale 1ns / 1ps
interface qrs_coef_if #(parameter int WIDTH = 16);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] coef_a;
    logic signed [WIDTH-1:0] coef_b;
    logic signed [WIDTH-1:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
    import qrs_pkg::*;
    logic                     valid;
    logic                     ready;
    root_case_t               root_case;
    logic signed [ROOT_W-1:0] root_one;
    logic signed [ROOT_W-1:0] root_two;

    modport source (output valid, root_case, root_one, root_two, input ready);
    modport sink (input valid, root_case, root_one, root_two, output ready);
endinterface

[design/qrs_sqrt.sv]
`timescale 1ns / 1ps
module qrs_sqrt #(
    parameter int R_W    = 33,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [2*R_W-1:0]  rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [R_W-1:0]    root,
    output logic [SIDE_W-1:0] out_side
);
    localparam int REM_W = R_W + 2;
    localparam int RAD_W = 2 * R_W;

    logic [R_W-1:0]               vld_reg;
    logic [R_W-1:0][REM_W-1:0]    rem_reg;
    logic [R_W-1:0][R_W-1:0]      root_reg;
    logic [R_W-1:0][RAD_W-1:0]    rad_reg;
    logic [R_W-1:0][SIDE_W-1:0]   side_reg;

    // one root bit per stage, restoring digit recurrence
    for (genvar k = 0; k < R_W; k++) begin : g_stage
        logic              prev_vld;
        logic [REM_W-1:0]  prev_rem;
        logic [R_W-1:0]    prev_root;
        logic [RAD_W-1:0]  prev_rad;
        logic [SIDE_W-1:0] prev_side;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign prev_vld  = in_vld;
            assign prev_rem  = '0;
            assign prev_root = '0;
            assign prev_rad  = rad;
            assign prev_side = in_side;
        end else begin : g_rest
            assign prev_vld  = vld_reg[k-1];
            assign prev_rem  = rem_reg[k-1];
            assign prev_root = root_reg[k-1];
            assign prev_rad  = rad_reg[k-1];
            assign prev_side = side_reg[k-1];
        end

        assign rem_sh = {prev_rem, prev_rad[RAD_W-1 -: 2]};
        assign trial  = {2'b00, prev_root, 2'b01};
        assign diff   = rem_sh - trial;
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= prev_vld;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k]  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                root_reg[k] <= {prev_root[R_W-2:0], ge};
                rad_reg[k]  <= prev_rad << 2;
                side_reg[k] <= prev_side;
            end
        end
    end

    assign out_vld  = vld_reg[R_W-1];
    assign root     = root_reg[R_W-1];
    assign out_side = side_reg[R_W-1];
endmodule

[design/qrs_div.sv]
`timescale 1ns / 1ps
module qrs_div #(
    parameter int NUM_W  = 35,
    parameter int DEN_W  = 17,
    parameter int SIDE_W = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic signed [NUM_W-1:0] num_one,
    input  logic signed [NUM_W-1:0] num_two,
    input  logic signed [DEN_W-1:0] den,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_vld,
    output logic [NUM_W-1:0]        quo_one,
    output logic [NUM_W-1:0]        quo_two,
    output logic                    neg_one,
    output logic                    neg_two,
    output logic [SIDE_W-1:0]       out_side
);
    // magnitude stage
    logic              mvld_reg;
    logic [NUM_W-1:0]  mnum_reg [2];
    logic              mneg_reg [2];
    logic [DEN_W-1:0]  mden_reg;
    logic [SIDE_W-1:0] mside_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mvld_reg <= 1'b0;
        end else if (en) begin
            mvld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            mnum_reg[0] <= num_one[NUM_W-1] ? NUM_W'(-num_one) : NUM_W'(num_one);
            mnum_reg[1] <= num_two[NUM_W-1] ? NUM_W'(-num_two) : NUM_W'(num_two);
            mneg_reg[0] <= num_one[NUM_W-1] ^ den[DEN_W-1];
            mneg_reg[1] <= num_two[NUM_W-1] ^ den[DEN_W-1];
            mden_reg    <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            mside_reg   <= in_side;
        end
    end

    logic [NUM_W-1:0]               vld_reg;
    logic [NUM_W-1:0][DEN_W-1:0]    den_reg;
    logic [NUM_W-1:0][SIDE_W-1:0]   side_reg;
    logic [NUM_W-1:0][1:0]          neg_reg;
    logic [1:0][NUM_W-1:0][DEN_W-1:0] rem_reg;
    logic [1:0][NUM_W-1:0][NUM_W-1:0] q_reg;

    // one quotient bit per stage, both lanes share the divisor
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              prev_vld;
        logic [DEN_W-1:0]  prev_den;
        logic [SIDE_W-1:0] prev_side;
        logic [1:0]        prev_neg;

        if (k == 0) begin : g_first
            assign prev_vld  = mvld_reg;
            assign prev_den  = mden_reg;
            assign prev_side = mside_reg;
            assign prev_neg  = {mneg_reg[1], mneg_reg[0]};
        end else begin : g_rest
            assign prev_vld  = vld_reg[k-1];
            assign prev_den  = den_reg[k-1];
            assign prev_side = side_reg[k-1];
            assign prev_neg  = neg_reg[k-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DEN_W-1:0] prev_rem;
            logic [NUM_W-1:0] prev_q;
            logic [DEN_W:0]   rem_sh;
            logic [DEN_W:0]   diff;
            logic             ge;

            if (k == 0) begin : g_first
                assign prev_rem = '0;
                assign prev_q   = mnum_reg[l];
            end else begin : g_rest
                assign prev_rem = rem_reg[l][k-1];
                assign prev_q   = q_reg[l][k-1];
            end

            assign rem_sh = {prev_rem, prev_q[NUM_W-1]};
            assign diff   = rem_sh - {1'b0, prev_den};
            assign ge     = (rem_sh >= {1'b0, prev_den});

            always_ff @(posedge clk) begin
                if (en) begin
                    rem_reg[l][k] <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                    q_reg[l][k]   <= {prev_q[NUM_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= prev_vld;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                den_reg[k]  <= prev_den;
                side_reg[k] <= prev_side;
                neg_reg[k]  <= prev_neg;
            end
        end
    end

    assign out_vld  = vld_reg[NUM_W-1];
    assign quo_one  = q_reg[0][NUM_W-1];
    assign quo_two  = q_reg[1][NUM_W-1];
    assign neg_one  = neg_reg[NUM_W-1][0];
    assign neg_two  = neg_reg[NUM_W-1][1];
    assign out_side = side_reg[NUM_W-1];
endmodule

[design/quadratic_real_root_solver.sv]
`timescale 1ns / 1ps
// path from request to result: capture, products, discriminant, square root, numerators, magnitude, divide, output
// throughput: one request per cycle while the result is not stalled; set by the fully pipelined root and divide stages
// a stalled result holds the whole pipeline in place, nothing is dropped
// reset: rst_n asynchronous active low, clears all valid bits, pipeline empty
module quadratic_real_root_solver #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    qrs_coef_if.sink   coef,
    qrs_root_if.source root
);
    import qrs_pkg::*;

    localparam int W      = COEF_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int PROD_W = 2 * W;
    localparam int D_W    = 2 * W + 3;
    localparam int R_W    = W + 1 + F;
    localparam int BASE_W = W + 1 + F;
    localparam int DEN_W  = W + 1;
    localparam int NUM_W  = W + F + 3;
    localparam int SIDE_W = CASE_W + BASE_W + DEN_W;
    localparam int QX_W   = ((NUM_W > ROOT_W) ? NUM_W : ROOT_W) + 1;
    localparam logic [QX_W-1:0] LIM = QX_W'(1) << (ROOT_W - 1);

    typedef struct packed {
        root_case_t               rcase;
        logic signed [BASE_W-1:0] base;
        logic signed [DEN_W-1:0]  den;
    } side_t;

    logic en;
    logic out_vld_reg;

    assign en         = !out_vld_reg || root.ready;
    assign coef.ready = en;

    // stage 0: capture request
    logic                v0_reg;
    logic signed [W-1:0] a0_reg, b0_reg, c0_reg;

    // stage 1: products
    logic                     v1_reg;
    logic signed [PROD_W-1:0] bb1_reg, ac1_reg;
    logic signed [W-1:0]      a1_reg, b1_reg;

    // stage 2: discriminant and classification
    logic                   v2_reg;
    logic [2*R_W-1:0]       rad2_reg;
    side_t                  side2_reg;

    logic signed [D_W-1:0]    d_w;
    logic signed [BASE_W-1:0] bx_w;
    root_case_t               case_w;

    always_comb begin
        d_w  = D_W'(bb1_reg) - (D_W'(ac1_reg) <<< 2);
        bx_w = BASE_W'(b1_reg);
        priority if (a1_reg == '0) begin
            case_w = CASE_DEGEN;
        end else if (d_w[D_W-1]) begin
            case_w = CASE_NONE;
        end else if (d_w == '0) begin
            case_w = CASE_DOUBLE;
        end else begin
            case_w = CASE_TWO;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= coef.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            a0_reg          <= coef.coef_a[W-1:0];
            b0_reg          <= coef.coef_b[W-1:0];
            c0_reg          <= coef.coef_c[W-1:0];
            bb1_reg         <= b0_reg * b0_reg;
            ac1_reg         <= a0_reg * c0_reg;
            a1_reg          <= a0_reg;
            b1_reg          <= b0_reg;
            rad2_reg        <= d_w[D_W-1] ? '0 : ((2*R_W)'(d_w) << (2 * F));
            side2_reg.rcase <= case_w;
            side2_reg.base  <= (-bx_w) <<< F;
            side2_reg.den   <= {a1_reg, 1'b0};
        end
    end

    // pipelined square root
    logic                 sq_vld;
    logic [R_W-1:0]       sq_root;
    logic [SIDE_W-1:0]    sq_side_bits;
    side_t                sq_side;

    qrs_sqrt #(
        .R_W    (R_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v2_reg),
        .rad      (rad2_reg),
        .in_side  (side2_reg),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_side_bits)
    );

    assign sq_side = side_t'(sq_side_bits);

    // stage: numerators -b*2^F +/- sqrt
    logic                    v3_reg;
    logic signed [NUM_W-1:0] n1_reg, n2_reg;
    logic signed [DEN_W-1:0] den3_reg;
    root_case_t              case3_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            n1_reg    <= NUM_W'(sq_side.base) + NUM_W'(sq_root);
            n2_reg    <= NUM_W'(sq_side.base) - NUM_W'(sq_root);
            den3_reg  <= sq_side.den;
            case3_reg <= sq_side.rcase;
        end
    end

    // pipelined divide of both numerators by 2a
    logic              dv_vld;
    logic [NUM_W-1:0]  q1, q2;
    logic              ng1, ng2;
    logic [CASE_W-1:0] dv_case;

    qrs_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W (CASE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v3_reg),
        .num_one  (n1_reg),
        .num_two  (n2_reg),
        .den      (den3_reg),
        .in_side  (case3_reg),
        .out_vld  (dv_vld),
        .quo_one  (q1),
        .quo_two  (q2),
        .neg_one  (ng1),
        .neg_two  (ng2),
        .out_side (dv_case)
    );

    // saturate a quotient magnitude and apply its sign
    function automatic logic [ROOT_W-1:0] sat_root(input logic [NUM_W-1:0] q,
                                                   input logic neg);
        logic [QX_W-1:0] qx;
        logic [QX_W-1:0] qs;
        qx = QX_W'(q);
        if (neg) begin
            qs = (qx > LIM) ? LIM : qx;
            qs = -qs;
        end else begin
            qs = (qx > LIM - 1'b1) ? LIM - 1'b1 : qx;
        end
        return qs[ROOT_W-1:0];
    endfunction

    // output register
    root_case_t               case_out_reg;
    logic signed [ROOT_W-1:0] r1_out_reg, r2_out_reg;
    logic                     has_roots;

    assign has_roots = (dv_case == CASE_TWO) || (dv_case == CASE_DOUBLE);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            case_out_reg <= dv_case;
            r1_out_reg   <= has_roots ? sat_root(q1, ng1) : '0;
            r2_out_reg   <= has_roots ? sat_root(q2, ng2) : '0;
        end
    end

    assign root.valid     = out_vld_reg;
    assign root.root_case = case_out_reg;
    assign root.root_one  = r1_out_reg;
    assign root.root_two  = r2_out_reg;
endmodule

[design/qrs_checker.sv]
`timescale 1ns / 1ps
module qrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  root_case,
    input logic [33:0] root_one,
    input logic [33:0] root_two
);
    import qrs_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // the pipeline moves whenever the output slot is free or taken
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("request ready does not follow output slot");

    // no real root or degenerate gives zero roots
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (root_case == CASE_NONE || root_case == CASE_DEGEN)
        |-> (root_one == '0) && (root_two == '0))
        else $error("nonzero root without real roots");

    // double root gives equal roots
    a_double: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_case == CASE_DOUBLE |-> root_one == root_two)
        else $error("double root fields differ");
endmodule

bind quadratic_real_root_solver qrs_checker u_qrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (coef.ready),
    .out_valid (root.valid),
    .out_ready (root.ready),
    .root_case (root.root_case),
    .root_one  (root.root_one),
    .root_two  (root.root_two)
);
